FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define FMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define FMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FMC_ASSERT(lbl, clk, rstn, prop, msg)
`define FMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: rtl/fmc_pkg.sv
// ---------------------------------------------------------------------------
// Flow mode controller package
// Register indexes, field widths and the fixed timing constants.
// ---------------------------------------------------------------------------
package fmc_pkg;

  localparam int unsigned DtWidth      = 10;
  localparam int unsigned RttWidth     = 16;
  localparam int unsigned RateWidth    = 8;
  localparam int unsigned PenaltyWidth = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegRttThreshold = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegGoodRate     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegBadRate      = 2'd2;

  // Reset values of the registers.
  localparam logic [RttWidth-1:0]  RttThresholdReset = 16'd250;
  localparam logic [RateWidth-1:0] GoodRateReset     = 8'd30;
  localparam logic [RateWidth-1:0] BadRateReset      = 8'd10;

  // Timing constants in milliseconds.
  localparam int unsigned GoodMinMs   = 10000;
  localparam int unsigned DecayMs     = 10000;
  localparam logic [PenaltyWidth-1:0] PenaltyMaxMs   = 16'd60000;
  localparam logic [PenaltyWidth-1:0] PenaltyMinMs   = 16'd1000;
  localparam logic [PenaltyWidth-1:0] PenaltyResetMs = 16'd4000;

endpackage

FILE: rtl/flow_mode_controller.sv
// ---------------------------------------------------------------------------
// Flow mode controller
// Good/bad mode flow control for one connection, one result per tick.
// ---------------------------------------------------------------------------
// Usage:
// Ticks arrive on the s_axis channel: tdata carries dt_ms and rtt_ms,
// tuser carries the connected flag. Each tick yields exactly one result
// on the m_axis channel: tdata carries send_rate and penalty_ms, tuser
// carries link_good and mode_changed.
// The datapath is an input register, one level of add/compare logic and
// a result register; a taken tick passes the input register, then the
// result register. One tick per cycle is sustained while results are
// taken; the single shared enable of both registers sets that figure.
// When the receiver stalls, both registers hold and s_axis_tready drops,
// so no result is lost; while the result register is full but being
// taken, a new tick is still accepted.
// Reset returns the registers to their default values, the mode to bad,
// the penalty to 4000 ms and both timers to zero.
// Configuration writes through cfg_we_i take effect at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_mode_controller #(
  parameter int unsigned TIME_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [fmc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // dt_ms[9:0], rtt_ms[25:10]
  input  logic                              s_axis_tuser,  // connected
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // send_rate[7:0], penalty_ms[23:8]
  output logic [1:0]                        m_axis_tuser   // link_good[0], mode_changed[1]
);

  logic [fmc_pkg::RttWidth-1:0]      rtt_thresh_q;
  logic [fmc_pkg::RateWidth-1:0]     good_rate_q;
  logic [fmc_pkg::RateWidth-1:0]     bad_rate_q;

  logic                              in_valid_q;
  logic [fmc_pkg::DtWidth-1:0]       in_dt_q;
  logic [fmc_pkg::RttWidth-1:0]      in_rtt_q;
  logic                              in_conn_q;

  logic                              mode_good_q;
  logic [fmc_pkg::PenaltyWidth-1:0]  penalty_q;
  logic [TIME_WIDTH-1:0]             good_time_q;
  logic [TIME_WIDTH-1:0]             accum_q;

  logic                              mode_good_d;
  logic [fmc_pkg::PenaltyWidth-1:0]  penalty_d;
  logic [TIME_WIDTH-1:0]             good_time_d;
  logic [TIME_WIDTH-1:0]             accum_d;
  logic                              changed;

  logic                              out_valid_q;
  logic                              out_good_q;
  logic                              out_changed_q;
  logic [fmc_pkg::RateWidth-1:0]     out_rate_q;
  logic [fmc_pkg::PenaltyWidth-1:0]  out_pen_q;

  logic                              advance;
  logic                              update;

  // Both stages move together whenever the result register can take data.
  assign advance       = !out_valid_q || m_axis_tready;
  assign update        = advance && in_valid_q;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_thresh_q <= fmc_pkg::RttThresholdReset;
      good_rate_q  <= fmc_pkg::GoodRateReset;
      bad_rate_q   <= fmc_pkg::BadRateReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmc_pkg::RegRttThreshold: rtt_thresh_q <= cfg_data_i;
        fmc_pkg::RegGoodRate:     good_rate_q  <= cfg_data_i[fmc_pkg::RateWidth-1:0];
        fmc_pkg::RegBadRate:      bad_rate_q   <= cfg_data_i[fmc_pkg::RateWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_axis_tvalid) begin
      in_dt_q   <= s_axis_tdata[9:0];
      in_rtt_q  <= s_axis_tdata[25:10];
      in_conn_q <= s_axis_tuser;
    end
  end

  fmc_step #(
    .TimeWidth(TIME_WIDTH)
  ) u_step (
    .mode_good_i     (mode_good_q),
    .penalty_i       (penalty_q),
    .good_time_i     (good_time_q),
    .accum_i         (accum_q),
    .dt_ms_i         (in_dt_q),
    .rtt_ms_i        (in_rtt_q),
    .connected_i     (in_conn_q),
    .rtt_threshold_i (rtt_thresh_q),
    .mode_good_o     (mode_good_d),
    .penalty_o       (penalty_d),
    .good_time_o     (good_time_d),
    .accum_o         (accum_d),
    .changed_o       (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_good_q <= 1'b0;
      penalty_q   <= fmc_pkg::PenaltyResetMs;
      good_time_q <= '0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        mode_good_q <= mode_good_d;
        penalty_q   <= penalty_d;
        good_time_q <= good_time_d;
        accum_q     <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      out_good_q    <= mode_good_d;
      out_changed_q <= changed;
      out_rate_q    <= mode_good_d ? good_rate_q : bad_rate_q;
      out_pen_q     <= penalty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pen_q, out_rate_q};
  assign m_axis_tuser  = {out_changed_q, out_good_q};

  `FMC_ASSERT(a_penalty_range, clk_i, rst_ni,
              penalty_q >= fmc_pkg::PenaltyMinMs && penalty_q <= fmc_pkg::PenaltyMaxMs,
              "penalty left its range")
  `FMC_ASSERT(a_change_toggles, clk_i, rst_ni,
              (update && changed) |=> (mode_good_q != $past(mode_good_q)),
              "mode change flagged without a mode toggle")
  `FMC_ASSERT(a_idle_tick_stable, clk_i, rst_ni,
              (update && !in_conn_q) |=> ($stable(mode_good_q) && $stable(penalty_q) &&
                                          $stable(good_time_q) && $stable(accum_q)),
              "disconnected tick changed the state")
  `FMC_ASSERT_NEVER(a_change_disconnected, clk_i, rst_ni,
                    in_valid_q && !in_conn_q && changed,
                    "mode change on a disconnected tick")

endmodule

FILE: rtl/fmc_step.sv
// ---------------------------------------------------------------------------
// Flow mode controller next-state logic
// Computes the mode, penalty and timers that one tick leaves behind.
// ---------------------------------------------------------------------------
module fmc_step #(
  parameter int unsigned TimeWidth = 20
) (
  input  logic                               mode_good_i,
  input  logic [fmc_pkg::PenaltyWidth-1:0]   penalty_i,
  input  logic [TimeWidth-1:0]               good_time_i,
  input  logic [TimeWidth-1:0]               accum_i,
  input  logic [fmc_pkg::DtWidth-1:0]        dt_ms_i,
  input  logic [fmc_pkg::RttWidth-1:0]       rtt_ms_i,
  input  logic                               connected_i,
  input  logic [fmc_pkg::RttWidth-1:0]       rtt_threshold_i,
  output logic                               mode_good_o,
  output logic [fmc_pkg::PenaltyWidth-1:0]   penalty_o,
  output logic [TimeWidth-1:0]               good_time_o,
  output logic [TimeWidth-1:0]               accum_o,
  output logic                               changed_o
);

  localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};
  localparam logic [TimeWidth-1:0] GoodMin = TimeWidth'(fmc_pkg::GoodMinMs);
  localparam logic [TimeWidth-1:0] Decay   = TimeWidth'(fmc_pkg::DecayMs);

  logic                              bad_rtt;
  logic [TimeWidth:0]                dt_ext;
  logic [TimeWidth:0]                good_sum;
  logic [TimeWidth:0]                accum_sum;
  logic [TimeWidth-1:0]              good_sat;
  logic [TimeWidth-1:0]              accum_sat;
  logic [fmc_pkg::PenaltyWidth:0]    pen_dbl;
  logic [fmc_pkg::PenaltyWidth-1:0]  pen_half;
  logic [TimeWidth-1:0]              good_bad_mode;
  logic [TimeWidth-1:0]              pen_ext;

  assign bad_rtt   = rtt_ms_i > rtt_threshold_i;
  assign dt_ext    = (TimeWidth+1)'(dt_ms_i);
  assign good_sum  = {1'b0, good_time_i} + dt_ext;
  assign accum_sum = {1'b0, accum_i} + dt_ext;
  // The timers stick at their largest value instead of wrapping.
  assign good_sat  = good_sum[TimeWidth]  ? TimeMax : good_sum[TimeWidth-1:0];
  assign accum_sat = accum_sum[TimeWidth] ? TimeMax : accum_sum[TimeWidth-1:0];
  assign pen_dbl   = {penalty_i, 1'b0};
  assign pen_half  = {1'b0, penalty_i[fmc_pkg::PenaltyWidth-1:1]};
  assign good_bad_mode = bad_rtt ? '0 : good_sat;
  assign pen_ext   = TimeWidth'(penalty_i);

  always_comb begin
    mode_good_o = mode_good_i;
    penalty_o   = penalty_i;
    good_time_o = good_time_i;
    accum_o     = accum_i;
    changed_o   = 1'b0;
    if (connected_i) begin
      if (mode_good_i) begin
        if (bad_rtt) begin
          mode_good_o = 1'b0;
          changed_o   = 1'b1;
          // A short stay in good mode makes the next bad spell longer.
          if (good_time_i < GoodMin && penalty_i < fmc_pkg::PenaltyMaxMs) begin
            penalty_o = (pen_dbl > {1'b0, fmc_pkg::PenaltyMaxMs}) ?
                        fmc_pkg::PenaltyMaxMs : pen_dbl[fmc_pkg::PenaltyWidth-1:0];
          end
          good_time_o = '0;
          accum_o     = '0;
        end else begin
          good_time_o = good_sat;
          accum_o     = accum_sat;
          if (accum_sat > Decay && penalty_i > fmc_pkg::PenaltyMinMs) begin
            accum_o   = '0;
            penalty_o = (pen_half < fmc_pkg::PenaltyMinMs) ? fmc_pkg::PenaltyMinMs : pen_half;
          end
        end
      end else begin
        good_time_o = good_bad_mode;
        if (good_bad_mode > pen_ext) begin
          good_time_o = '0;
          accum_o     = '0;
          mode_good_o = 1'b1;
          changed_o   = 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Flow mode controller testbench
// Sends ticks with random handshake gaps and stalls, predicts the mode,
// send rate and penalty of every tick, and checks each result in order.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned TimeW      = 20;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHold   = 300;
  localparam logic [fmc_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [fmc_pkg::DtWidth-1:0]  dt;
    logic [fmc_pkg::RttWidth-1:0] rtt;
    logic                         conn;
  } tick_t;

  typedef struct {
    tick_t       tick;
    int unsigned gap;
  } pending_tick_t;

  typedef struct packed {
    logic                             link_good;
    logic [fmc_pkg::RateWidth-1:0]    send_rate;
    logic [fmc_pkg::PenaltyWidth-1:0] penalty_ms;
    logic                             mode_changed;
  } flow_result_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [fmc_pkg::CfgIdxWidth-1:0]  cfg_idx_i     = '0;
  logic [fmc_pkg::CfgDataWidth-1:0] cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [31:0]                      s_axis_tdata  = '0;  // dt_ms[9:0], rtt_ms[25:10]
  logic                             s_axis_tuser  = 1'b0; // connected
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [23:0]                      m_axis_tdata;  // send_rate[7:0], penalty_ms[23:8]
  logic [1:0]                       m_axis_tuser;  // link_good[0], mode_changed[1]

  flow_mode_controller #(
    .TIME_WIDTH(TimeW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predicted configuration and controller state.
  logic [fmc_pkg::RttWidth-1:0]     cf_rtt_threshold = fmc_pkg::RttThresholdReset;
  logic [fmc_pkg::RateWidth-1:0]    cf_good_rate     = fmc_pkg::GoodRateReset;
  logic [fmc_pkg::RateWidth-1:0]    cf_bad_rate      = fmc_pkg::BadRateReset;
  logic                             pr_mode_good     = 1'b0;
  logic [fmc_pkg::PenaltyWidth-1:0] pr_penalty       = fmc_pkg::PenaltyResetMs;
  logic [TimeW-1:0]                 pr_good_time     = '0;
  logic [TimeW-1:0]                 pr_penalty_accum = '0;

  pending_tick_t tick_q[$];
  flow_result_t  flow_exp_q[$];

  tick_t        cur_tick;
  int unsigned  gap_left      = 0;
  int unsigned  tx_calm       = 0;
  int unsigned  rx_calm       = 0;
  int unsigned  stall_left    = 0;
  int unsigned  hold_left     = 0;
  logic         rx_hold_req   = 1'b0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  cycle_cnt     = 0;
  flow_result_t mon_got;
  flow_result_t mon_want;

  function automatic logic [TimeW-1:0] sat_time_add(logic [TimeW-1:0] a,
                                                     logic [fmc_pkg::DtWidth-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + (TimeW+1)'(b);
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

  // Advances the predicted controller by one tick and returns its result.
  function automatic flow_result_t advance_flow(tick_t t);
    flow_result_t res;
    logic         bad_rtt;
    logic         changed;
    int unsigned  doubled;
    bad_rtt = t.rtt > cf_rtt_threshold;
    changed = 1'b0;
    if (t.conn) begin
      if (pr_mode_good) begin
        if (bad_rtt) begin
          pr_mode_good = 1'b0;
          changed      = 1'b1;
          // A short good spell makes the next one harder to earn.
          if (pr_good_time < fmc_pkg::GoodMinMs && pr_penalty < fmc_pkg::PenaltyMaxMs) begin
            doubled    = 2 * pr_penalty;
            pr_penalty = (doubled > fmc_pkg::PenaltyMaxMs) ? fmc_pkg::PenaltyMaxMs
                                                           : doubled[15:0];
          end
          pr_good_time     = '0;
          pr_penalty_accum = '0;
        end else begin
          pr_good_time     = sat_time_add(pr_good_time, t.dt);
          pr_penalty_accum = sat_time_add(pr_penalty_accum, t.dt);
          if (pr_penalty_accum > fmc_pkg::DecayMs && pr_penalty > fmc_pkg::PenaltyMinMs) begin
            pr_penalty_accum = '0;
            pr_penalty       = pr_penalty >> 1;
            if (pr_penalty < fmc_pkg::PenaltyMinMs) begin
              pr_penalty = fmc_pkg::PenaltyMinMs;
            end
          end
        end
      end else begin
        if (bad_rtt) begin
          pr_good_time = '0;
        end else begin
          pr_good_time = sat_time_add(pr_good_time, t.dt);
        end
        if (pr_good_time > pr_penalty) begin
          pr_good_time     = '0;
          pr_penalty_accum = '0;
          pr_mode_good     = 1'b1;
          changed          = 1'b1;
        end
      end
    end
    res.link_good    = pr_mode_good;
    res.send_rate    = pr_mode_good ? cf_good_rate : cf_bad_rate;
    res.penalty_ms   = pr_penalty;
    res.mode_changed = changed;
    return res;
  endfunction

  // Mostly no idling, some short gaps, a few long ones, and calm stretches.
  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned pick;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [fmc_pkg::RttWidth-1:0] good_rtt();
    return 16'($urandom_range(0, int'(cf_rtt_threshold)));
  endfunction

  function automatic logic [fmc_pkg::RttWidth-1:0] bad_rtt();
    if (cf_rtt_threshold == '1) return 16'($urandom);
    return 16'($urandom_range(int'(cf_rtt_threshold) + 1, 65535));
  endfunction

  task automatic queue_tick(input int unsigned dt, input logic [fmc_pkg::RttWidth-1:0] rtt,
                            input logic conn, input logic steady);
    pending_tick_t p;
    p.tick.dt   = dt[fmc_pkg::DtWidth-1:0];
    p.tick.rtt  = rtt;
    p.tick.conn = conn;
    p.gap       = steady ? 0 : idle_len(tx_calm);
    tick_q.push_back(p);
  endtask

  // Runs of good RTT long enough to change mode, bursts of bad RTT,
  // and a share of fully random ticks.
  task automatic queue_random(input int unsigned n);
    int unsigned made;
    int unsigned kind;
    int unsigned run;
    int unsigned dt;
    logic        conn;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        run = $urandom_range(1, 40);
        repeat (run) begin
          conn = ($urandom_range(0, 19) != 0);
          dt   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(600, 1023);
          queue_tick(dt, good_rtt(), conn, 1'b0);
          if (conn) made++;
        end
      end else if (kind < 75) begin
        run = $urandom_range(1, 3);
        repeat (run) begin
          queue_tick($urandom_range(0, 1023), bad_rtt(), 1'b1, 1'b0);
          made++;
        end
      end else begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          conn = 1'($urandom);
          queue_tick($urandom_range(0, 1023), 16'($urandom), conn, 1'b0);
          if (conn) made++;
        end
      end
    end
  endtask

  // Waits until every tick has been sent and every result has come back.
  task automatic drain();
    while (tick_q.size() != 0 || s_axis_tvalid || flow_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fmc_pkg::CfgIdxWidth-1:0] idx,
                           input logic [fmc_pkg::CfgDataWidth-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      fmc_pkg::RegRttThreshold: cf_rtt_threshold = value;
      fmc_pkg::RegGoodRate:     cf_good_rate     = value[fmc_pkg::RateWidth-1:0];
      fmc_pkg::RegBadRate:      cf_bad_rate      = value[fmc_pkg::RateWidth-1:0];
      default: ;
    endcase
  endtask

  // The write to the unused index must leave every register alone.
  task automatic apply_config(input logic [fmc_pkg::CfgDataWidth-1:0] thr,
                              input logic [fmc_pkg::CfgDataWidth-1:0] good_rate,
                              input logic [fmc_pkg::CfgDataWidth-1:0] bad_rate);
    write_reg(fmc_pkg::RegRttThreshold, thr);
    write_reg(fmc_pkg::RegGoodRate, good_rate);
    write_reg(fmc_pkg::RegBadRate, bad_rate);
    write_reg(RegUnused, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Tick driver: predicts each accepted item, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        flow_exp_q.push_back(advance_flow(cur_tick));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick      = tick_q[0].tick;
          gap_left      = tick_q[0].gap;
          void'(tick_q.pop_front());
          s_axis_tdata  <= {6'b0, cur_tick.rtt, cur_tick.dt};
          s_axis_tuser  <= cur_tick.conn;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver readiness, with random stalls and one long hold.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_len(rx_calm);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.link_good    = m_axis_tuser[0];
      mon_got.mode_changed = m_axis_tuser[1];
      mon_got.send_rate    = m_axis_tdata[7:0];
      mon_got.penalty_ms   = m_axis_tdata[23:8];
      if (flow_exp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 50) begin
          $display("%0t: unexpected result good=%0d rate=%0d penalty=%0d changed=%0d",
                   $time, mon_got.link_good, mon_got.send_rate, mon_got.penalty_ms,
                   mon_got.mode_changed);
        end
      end else begin
        mon_want = flow_exp_q.pop_front();
        if (mon_got !== mon_want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 50) begin
            $display({"%0t: result mismatch: expected good=%0d rate=%0d penalty=%0d ",
                      "changed=%0d, got good=%0d rate=%0d penalty=%0d changed=%0d"},
                     $time, mon_want.link_good, mon_want.send_rate, mon_want.penalty_ms,
                     mon_want.mode_changed, mon_got.link_good, mon_got.send_rate,
                     mon_got.penalty_ms, mon_got.mode_changed);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: a disconnected tick, field extremes, the threshold
    // edge, a climb into good mode and an early fall that doubles the penalty.
    queue_tick(1023, 16'hFFFF, 1'b0, 1'b0);
    queue_tick(0, 16'h0000, 1'b1, 1'b0);
    queue_tick(1023, 16'd250, 1'b1, 1'b0);
    queue_tick(1023, 16'd251, 1'b1, 1'b0);
    repeat (4) queue_tick(1023, 16'd0, 1'b1, 1'b0);
    queue_tick(1023, 16'hFFFF, 1'b0, 1'b0);
    queue_tick(0, 16'hFFFF, 1'b1, 1'b0);
    queue_random(120);
    drain();

    // Every nonzero RTT is bad; a zero good rate passes straight through.
    apply_config(16'd0, 16'd0, 16'd255);
    queue_tick(1000, 16'd1, 1'b1, 1'b0);
    queue_random(80);
    drain();

    // Nothing is bad: a long good spell decays the penalty to its floor
    // and holds it there. Upper rate bits must be dropped.
    apply_config(16'hFFFF, 16'hFFFF, 16'hAB01);
    queue_random(60);
    repeat (120) queue_tick($urandom_range(1000, 1023), 16'($urandom), 1'b1, 1'b0);
    drain();

    // The receiver holds off while ticks keep coming back to back.
    apply_config(16'($urandom_range(100, 3000)), 16'($urandom_range(0, 255)),
                 16'($urandom_range(0, 255)));
    @(negedge clk_i);
    rx_hold_req = 1'b1;
    repeat (40) queue_tick($urandom_range(0, 1023), good_rtt(), 1'b1, 1'b1);
    queue_random(150);
    drain();

    apply_config(16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(80);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
